// File: design/sign_command_framer_defines.svh
// ----------------------------------------------------------------------------
// Sign command framer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIGN_COMMAND_FRAMER_DEFINES_SVH
`define SIGN_COMMAND_FRAMER_DEFINES_SVH

// same-cycle implication
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/scf_pkg.sv
// ----------------------------------------------------------------------------
// Sign command framer package
// Frame constants, sequencer step codes and the emit bundle.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam logic [7:0]  FRAME_START = 8'hA0;
  localparam logic [7:0]  FRAME_KIND  = 8'h01;
  localparam logic [7:0]  FRAME_TAIL0 = 8'h00;
  localparam logic [7:0]  FRAME_TAIL1 = 8'h50;
  localparam logic [15:0] FRAME_EXTRA = 16'd8;

  typedef enum logic [3:0] {
    S_PRE0,
    S_PRE1,
    S_PRE2,
    S_PRE3,
    S_DATA,
    S_SUM_LO,
    S_SUM_HI,
    S_TAIL0,
    S_TAIL1
  } step_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } emit_t;

endpackage

// File: design/scf_seq.sv
// ----------------------------------------------------------------------------
// Sign command framer sequencer
// Input register, frame step sequencer and running checksum.
// ----------------------------------------------------------------------------
`include "sign_command_framer_defines.svh"

module scf_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     data_byte,
  input  logic           first,
  input  logic           last,
  input  logic [15:0]    payload_length,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           take,
  output scf_pkg::emit_t emit
);
  import scf_pkg::*;

  logic        item_valid;
  logic [7:0]  item_data;
  logic        item_last;
  logic [15:0] total;
  step_t       step;
  step_t       step_succ;
  logic        in_frame;
  logic [15:0] sum;

  logic        in_accept;
  logic        stray;
  logic        load;
  logic        summed;
  logic        final_step;
  logic        fire;
  logic        done;
  logic [7:0]  cur_byte;

  assign in_accept = in_valid && in_ready;
  assign stray     = !first && !in_frame;
  assign load      = in_accept && !stray;
  assign fire      = item_valid && take;
  assign done      = fire && final_step;
  assign in_ready  = !item_valid || done;

  // next step
  always_comb begin
    unique case (step)
      S_PRE0:   step_succ = S_PRE1;
      S_PRE1:   step_succ = S_PRE2;
      S_PRE2:   step_succ = S_PRE3;
      S_PRE3:   step_succ = S_DATA;
      S_DATA:   step_succ = S_SUM_LO;
      S_SUM_LO: step_succ = S_SUM_HI;
      S_SUM_HI: step_succ = S_TAIL0;
      S_TAIL0:  step_succ = S_TAIL1;
      S_TAIL1:  step_succ = S_TAIL1;
      default:  step_succ = S_TAIL1;
    endcase
  end

  // step outputs
  always_comb begin
    summed     = 1'b0;
    final_step = 1'b0;
    unique case (step)
      S_PRE0: begin
        cur_byte = FRAME_START;
        summed   = 1'b1;
      end
      S_PRE1: begin
        cur_byte = total[7:0];
        summed   = 1'b1;
      end
      S_PRE2: begin
        cur_byte = total[15:8];
        summed   = 1'b1;
      end
      S_PRE3: begin
        cur_byte = FRAME_KIND;
        summed   = 1'b1;
      end
      S_DATA: begin
        cur_byte   = item_data;
        summed     = 1'b1;
        final_step = !item_last;
      end
      S_SUM_LO: cur_byte = sum[7:0];
      S_SUM_HI: cur_byte = sum[15:8];
      S_TAIL0:  cur_byte = FRAME_TAIL0;
      S_TAIL1: begin
        cur_byte   = FRAME_TAIL1;
        final_step = 1'b1;
      end
      default:  cur_byte = FRAME_TAIL0;
    endcase
  end

  assign emit.valid     = item_valid;
  assign emit.out_byte  = cur_byte;
  assign emit.run_last  = final_step;
  assign emit.frame_end = (step == S_TAIL1);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      step       <= S_PRE0;
      in_frame   <= 1'b0;
      sum        <= '0;
    end else begin
      if (in_accept && !stray) begin
        in_frame <= !last;
      end
      if (load) begin
        item_valid <= 1'b1;
        step       <= first ? S_PRE0 : S_DATA;
      end else if (done) begin
        item_valid <= 1'b0;
      end else if (fire) begin
        step <= step_succ;
      end
      if (fire && summed) begin
        sum <= ((step == S_PRE0) ? 16'd0 : sum) + {8'd0, cur_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_data <= data_byte;
      item_last <= last;
      if (first) begin
        total <= payload_length + FRAME_EXTRA;
      end
    end
  end

  `SCF_ASSERT_NOW(a_end_is_last, emit.valid && emit.frame_end, emit.run_last,
    "frame end byte not marked as final result")
  `SCF_ASSERT_NEXT(a_prefix_advance, fire && (step == S_PRE0),
    item_valid && (step == S_PRE1), "prefix did not advance")
  `SCF_ASSERT_NOW(a_hold_mid_frame, item_valid && (step == S_PRE2), !in_ready,
    "input taken in the middle of a prefix")
  `SCF_ASSERT_NEXT(a_tail_closes, done && (step == S_TAIL1), !in_frame || item_valid,
    "frame still open after terminator")

endmodule

// File: design/scf_out_reg.sv
// ----------------------------------------------------------------------------
// Sign command framer output register
// Holds one result byte until the receiver takes it.
// ----------------------------------------------------------------------------
module scf_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  scf_pkg::emit_t emit,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           frame_end
);
  import scf_pkg::*;

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit.valid) begin
      out_byte  <= emit.out_byte;
      run_last  <= emit.run_last;
      frame_end <= emit.frame_end;
    end
  end

endmodule

// File: design/sign_command_framer.sv
// ----------------------------------------------------------------------------
// Sign command framer
// Wraps a payload byte stream into prefix, payload, checksum and terminator.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one payload byte with its first and
// last marks and, on a first byte, the payload length. Output channel:
// out_valid/out_ready carry one framed byte per transaction; run_last marks
// the final byte caused by an input, frame_end marks the closing 0x50.
// A stray byte (not first, no frame open) is accepted and dropped.
// Path: an accepted byte is captured in the input register at the accepting
// edge; each result byte of it then passes through the output register.
// Output bytes per input: a plain payload byte yields one; a first byte
// yields five (four prefix bytes and the data), a last byte five (data, two
// checksum bytes, two terminator bytes), a first-and-last byte nine. One
// byte leaves the step sequencer per cycle while the output register can
// take it; that sets the rate.
// Reset (rst, synchronous): clears the open-frame flag, checksum and both
// registers' valid flags.
// Stall: when out_ready is low the output register holds, the sequencer
// stops once that register is full, and in_ready stays low while an item
// waits in the input register.
// ----------------------------------------------------------------------------
module sign_command_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic        last,
  input  logic [15:0] payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        frame_end
);
  import scf_pkg::*;

  emit_t emit;
  logic  take;

  scf_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .first          (first),
    .last           (last),
    .payload_length (payload_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .take           (take),
    .emit           (emit)
  );

  scf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule
